>>> sv/vpsh_pkg.sv
// shared constants and types for the varispeed pitch shifter
package vpsh_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DEF_RING_DEPTH = 8192;
    localparam int DEF_FRAC_BITS  = 12;
    localparam int FRAC_MAX_W     = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    // wide enough for 1.0 at the largest fraction width
    localparam int STEP_W      = 17;
    localparam int STEP_CMP_W  = 20;

    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_Q_PTR_W = 2;
    localparam int OUT_Q_CNT_W = 3;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_STEP = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_EN  = CFG_INDEX_W'(1);

    // per-item control handed from the ring control to the interpolator
    typedef struct packed {
        logic                       valid;
        logic                       bypass;
        logic                       fwd_a;
        logic                       a_ok;
        logic                       b_ok;
        logic signed [SAMPLE_W-1:0] sample;
        logic [FRAC_MAX_W-1:0]      frac;
    } vpsh_tag_t;

endpackage

>>> sv/vpsh_ring_mem.sv
// sample ring memory, one write port and one registered read port
module vpsh_ring_mem import vpsh_pkg::*; #(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int IDX_W      = $clog2(RING_DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/vpsh_interp.sv
// linear interpolation datapath: operand capture, weighting multiply, sum and saturate
module vpsh_interp import vpsh_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vpsh_tag_t                  tag_in,
    input  logic signed [SAMPLE_W-1:0] rd_data,
    output logic                       res_valid,
    output logic signed [SAMPLE_W-1:0] res_sample,
    output logic [1:0]                 busy
);

    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [FRAC_BITS:0]        ONE_W = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]   BIAS  = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0]   Q_MAX = SUM_W'(SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0]   Q_MIN = SUM_W'(SAMPLE_MIN);

    // stage 2: first neighbor captured, second arriving from memory
    logic                       s2_vld_reg;
    logic                       s2_byp_reg;
    logic                       s2_b_ok_reg;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic [FRAC_BITS-1:0]       s2_frac_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] a_next;

    // stage 3: weighted products
    logic                       s3_vld_reg;
    logic                       s3_byp_reg;
    logic signed [SAMPLE_W-1:0] s3_sample_reg;
    logic signed [PROD_W-1:0]   prod_a_reg;
    logic signed [PROD_W-1:0]   prod_b_reg;
    logic signed [PROD_W-1:0]   prod_a_next;
    logic signed [PROD_W-1:0]   prod_b_next;

    logic [FRAC_BITS:0]           wa;
    logic signed [FRAC_BITS+1:0]  wa_s;
    logic signed [FRAC_BITS:0]    wb_s;
    logic signed [SAMPLE_W-1:0]   b_val;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      sum_adj;
    logic signed [SUM_W-1:0]      q;
    logic signed [SAMPLE_W-1:0]   q_sat;

    always_comb begin
        priority if (tag_in.fwd_a) begin
            a_next = tag_in.sample;
        end else if (tag_in.a_ok) begin
            a_next = rd_data;
        end else begin
            a_next = '0;
        end
    end

    always_comb begin
        wa          = ONE_W - {1'b0, s2_frac_reg};
        wa_s        = $signed({1'b0, wa});
        wb_s        = $signed({1'b0, s2_frac_reg});
        b_val       = s2_b_ok_reg ? rd_data : '0;
        prod_a_next = a_reg * wa_s;
        prod_b_next = b_val * wb_s;
    end

    // truncate toward zero, then clamp to the sample range
    always_comb begin
        sum     = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);
        sum_adj = sum + (sum[SUM_W-1] ? BIAS : '0);
        q       = sum_adj >>> FRAC_BITS;
        priority if (q > Q_MAX) begin
            q_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (q < Q_MIN) begin
            q_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            q_sat = q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s2_vld_reg <= tag_in.valid;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_byp_reg    <= tag_in.bypass;
        s2_b_ok_reg   <= tag_in.b_ok;
        s2_sample_reg <= tag_in.sample;
        s2_frac_reg   <= tag_in.frac[FRAC_BITS-1:0];
        a_reg         <= a_next;
        s3_byp_reg    <= s2_byp_reg;
        s3_sample_reg <= s2_sample_reg;
        prod_a_reg    <= prod_a_next;
        prod_b_reg    <= prod_b_next;
    end

    assign res_valid  = s3_vld_reg;
    assign res_sample = s3_byp_reg ? s3_sample_reg : q_sat;
    assign busy       = {s3_vld_reg, s2_vld_reg};

endmodule

>>> sv/vpsh_out_queue.sv
// small result queue that decouples the datapath from the receiver
module vpsh_out_queue import vpsh_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_data,
    input  logic                       pop,
    output logic                       not_empty,
    output logic signed [SAMPLE_W-1:0] head_data,
    output logic [OUT_Q_CNT_W-1:0]     count
);

    logic signed [SAMPLE_W-1:0] slot_reg [OUT_Q_DEPTH];
    logic [OUT_Q_PTR_W-1:0]     wr_ptr_reg;
    logic [OUT_Q_PTR_W-1:0]     rd_ptr_reg;
    logic [OUT_Q_CNT_W-1:0]     count_reg;
    logic [OUT_Q_CNT_W-1:0]     count_next;

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + OUT_Q_CNT_W'(1);
            2'b01:   count_next = count_reg - OUT_Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> sv/varispeed_pitch_shifter_unit.sv
// varispeed pitch shifter: ring memory resampler with linear interpolation
//
// Input beats (s_valid/s_ready, s_in_sample) carry one signed 16-bit sample each;
// every input beat yields exactly one output beat (m_valid/m_ready, m_out_sample)
// in the same order. Registers are written on the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data), always ready: index 0 is the pitch step in unsigned
// Q3.FRAC_BITS (clamped to 0.25..4.0), index 1 enables the effect; other indexes
// are dropped. Write registers only while no beat is in flight.
// Unless bypassed, each beat is written to the ring; the ring is read at the
// fractional read position, the two neighbors through one shared read port, so
// no new beat is taken while the second neighbor is read.
// With the effect off or a step of exactly 1.0 the sample passes through and
// neither the ring nor the positions move.
// Results wait in a 4-entry queue; when the receiver stalls, input is held off
// once queued plus in-flight beats reach four, and nothing is dropped.
// Reset clears the positions and sets the step to 1.0 with the effect off. The
// ring needs no clearing pass: a wrap flag and the write index track written
// entries, and unwritten ones read as zero.
module varispeed_pitch_shifter_unit import vpsh_pkg::*; #(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_in_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int POS_W = IDX_W + FRAC_BITS;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [POS_W:0]        POS_SPAN = (POS_W + 1)'(RING_DEPTH) << FRAC_BITS;
    localparam logic [STEP_W-1:0]     ONE_STEP = STEP_W'(1) << FRAC_BITS;
    localparam logic [STEP_CMP_W-1:0] STEP_MIN = STEP_CMP_W'(1) << (FRAC_BITS - 2);
    localparam logic [STEP_CMP_W-1:0] STEP_MAX = STEP_CMP_W'(4) << FRAC_BITS;

    logic                   phase_reg;
    logic [IDX_W-1:0]       wi_reg;
    logic                   wrapped_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       ip1_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   en_reg;
    vpsh_tag_t              tag_reg;
    vpsh_tag_t              tag_next;

    logic                   accept;
    logic                   bypass;
    logic                   advance;
    logic [IDX_W-1:0]       ip;
    logic [IDX_W-1:0]       ip1;
    logic [IDX_W-1:0]       wi_inc;
    logic                   wrapped_next;
    logic [POS_W:0]         pos_sum;
    logic [POS_W-1:0]       pos_next;
    logic [STEP_CMP_W-1:0]  cfg_step_ext;
    logic [STEP_W-1:0]      cfg_step;

    logic [IDX_W-1:0]           mem_rd_addr;
    logic signed [SAMPLE_W-1:0] mem_rd_data;
    logic                       res_valid;
    logic signed [SAMPLE_W-1:0] res_sample;
    logic [1:0]                 busy;
    logic [OUT_Q_CNT_W-1:0]     q_count;
    logic [OUT_Q_CNT_W:0]       occupancy;

    assign occupancy = (OUT_Q_CNT_W + 1)'(q_count) + (OUT_Q_CNT_W + 1)'(tag_reg.valid)
                     + (OUT_Q_CNT_W + 1)'(busy[0]) + (OUT_Q_CNT_W + 1)'(busy[1]);
    assign s_ready   = !phase_reg && (occupancy < (OUT_Q_CNT_W + 1)'(OUT_Q_DEPTH));
    assign accept    = s_valid && s_ready;
    assign bypass    = !en_reg || (step_reg == ONE_STEP);
    assign advance   = accept && !bypass;
    assign cfg_ready = 1'b1;

    always_comb begin
        ip           = pos_reg[POS_W-1:FRAC_BITS];
        ip1          = (ip == LAST_IDX) ? '0 : ip + IDX_W'(1);
        wi_inc       = (wi_reg == LAST_IDX) ? '0 : wi_reg + IDX_W'(1);
        wrapped_next = wrapped_reg || (wi_reg == LAST_IDX);
        pos_sum      = (POS_W + 1)'(pos_reg) + (POS_W + 1)'(step_reg);
        pos_next     = (pos_sum >= POS_SPAN) ? POS_W'(pos_sum - POS_SPAN) : POS_W'(pos_sum);
    end

    // entries count as written once the write index has passed them
    always_comb begin
        tag_next.valid  = accept;
        tag_next.bypass = bypass;
        tag_next.fwd_a  = (ip == wi_reg);
        tag_next.a_ok   = wrapped_reg || (ip < wi_reg);
        tag_next.b_ok   = wrapped_next || (ip1 < wi_inc);
        tag_next.sample = s_in_sample;
        tag_next.frac   = FRAC_MAX_W'(pos_reg[FRAC_BITS-1:0]);
    end

    always_comb begin
        cfg_step_ext = STEP_CMP_W'(cfg_data);
        priority if (cfg_step_ext < STEP_MIN) begin
            cfg_step = STEP_W'(STEP_MIN);
        end else if (cfg_step_ext > STEP_MAX) begin
            cfg_step = STEP_W'(STEP_MAX);
        end else begin
            cfg_step = STEP_W'(cfg_step_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            wi_reg        <= '0;
            wrapped_reg   <= 1'b0;
            pos_reg       <= '0;
            step_reg      <= ONE_STEP;
            en_reg        <= 1'b0;
            tag_reg.valid <= 1'b0;
        end else begin
            phase_reg <= accept;
            tag_reg   <= tag_next;
            if (advance) begin
                wi_reg      <= wi_inc;
                wrapped_reg <= wrapped_next;
                pos_reg     <= pos_next;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PITCH_STEP: step_reg <= cfg_step;
                    REG_EFFECT_EN:  en_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ip1_reg <= ip1;
        end
    end

    // first neighbor on the accept cycle, second in the cycle after
    assign mem_rd_addr = phase_reg ? ip1_reg : ip;

    vpsh_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_ring_mem (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (wi_reg),
        .wr_data (s_in_sample),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    vpsh_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tag_in     (tag_reg),
        .rd_data    (mem_rd_data),
        .res_valid  (res_valid),
        .res_sample (res_sample),
        .busy       (busy)
    );

    vpsh_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_sample),
        .pop       (m_valid && m_ready),
        .not_empty (m_valid),
        .head_data (m_out_sample),
        .count     (q_count)
    );

    a_two_cycle_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input beat taken on the second-read cycle");

    a_no_overcommit: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (OUT_Q_CNT_W + 1)'(OUT_Q_DEPTH))
        else $error("more beats in flight than the result queue can hold");

    a_bypass_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && bypass |=> $stable(pos_reg) && $stable(wi_reg) && $stable(wrapped_reg))
        else $error("bypassed beat moved the ring state");

    a_no_write_on_second_read: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> !advance)
        else $error("ring written while the second neighbor is read");

endmodule
